// ----- hw/rtl/bitmap_run_page_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// Bitmap run page allocator: assertion macros
// Shared concurrent assertion forms, clocked on clk, idle under arst_n.
// ---------------------------------------------------------------------------
`ifndef BITMAP_RUN_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BRA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bra_pkg.sv -----
// ---------------------------------------------------------------------------
// Bitmap run page allocator: package
// Sizes, request and status codes, and the structs shared between modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

	localparam int unsigned MAX_PAGES     = 1024;
	localparam int unsigned MAP_WORD_BITS = 32;
	localparam int unsigned MAP_WORDS     = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int unsigned BIT_W         = $clog2(MAP_WORD_BITS);
	localparam int unsigned ADDR_W        = $clog2(MAP_WORDS);

	// field widths
	localparam int unsigned PAGE_W = 10;
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned LEN_W  = 12;

	typedef logic [MAP_WORD_BITS-1:0] map_word_t;
	typedef logic [ADDR_W-1:0]        word_addr_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [PAGE_W-1:0]        page_t;

	localparam map_word_t ALL_ONES      = '1;
	localparam cnt_t      PAGE_LIMIT    = CNT_W'(MAX_PAGES);
	localparam cnt_t      NUM_PAGES_RST = CNT_W'(1024);

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_MARK  = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_NEG   = 2'd3;

	typedef struct packed {
		logic       rd_en;
		word_addr_t rd_addr;
		logic       wr_en;
		word_addr_t wr_addr;
		map_word_t  wr_data;
	} ram_req_t;

	typedef struct packed {
		logic hit;
		cnt_t hit_start;
		cnt_t next_len;
		cnt_t next_start;
	} scan_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bra_req_if.sv -----
// ---------------------------------------------------------------------------
// Bitmap run page allocator: request channel
// Valid/ready channel carrying one allocate, free or mark request per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface bra_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            req_type;
	logic [bra_pkg::PAGE_W-1:0]            first_page;
	logic signed [bra_pkg::LEN_W-1:0]      run_length;

	modport source (output valid, output req_type, output first_page, output run_length,
		input ready);
	modport sink (input valid, input req_type, input first_page, input run_length,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bra_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Bitmap run page allocator: response channel
// Valid/ready channel carrying one status and start page per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface bra_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [bra_pkg::PAGE_W-1:0] alloc_start;

	modport source (output valid, output status, output alloc_start, input ready);
	modport sink (input valid, input status, input alloc_start, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bra_map_ram.sv -----
// ---------------------------------------------------------------------------
// Bitmap run page allocator: map memory
// One-read one-write bitmap store, registered read; per-row valid bits make
// rows never written since reset read as all free.
// ---------------------------------------------------------------------------
`default_nettype none

module bra_map_ram (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bra_pkg::ram_req_t  ram_req,
	output bra_pkg::map_word_t      rd_data
);

	bra_pkg::map_word_t              mem [bra_pkg::MAP_WORDS];
	logic [bra_pkg::MAP_WORDS-1:0]   row_valid_q;
	bra_pkg::map_word_t              rd_data_q;
	logic                            rd_valid_q;

	always_ff @(posedge clk) begin
		if (ram_req.wr_en) begin
			mem[ram_req.wr_addr] <= ram_req.wr_data;
		end
		if (ram_req.rd_en) begin
			rd_data_q <= mem[ram_req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (ram_req.rd_en) begin
				rd_valid_q <= row_valid_q[ram_req.rd_addr];
			end
			if (ram_req.wr_en) begin
				row_valid_q[ram_req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/bra_scan.sv -----
// ---------------------------------------------------------------------------
// Bitmap run page allocator: word scanner
// First-fit search over one bitmap word, continuing the free run carried in
// from lower words; pages at or above the limit count as used.
// ---------------------------------------------------------------------------
`default_nettype none

module bra_scan (
	input  wire bra_pkg::map_word_t  word,
	input  wire bra_pkg::word_addr_t word_idx,
	input  wire bra_pkg::cnt_t       limit,
	input  wire bra_pkg::cnt_t       len,
	input  wire bra_pkg::cnt_t       carry_len,
	input  wire bra_pkg::cnt_t       carry_start,
	output bra_pkg::scan_res_t       res
);

	logic [bra_pkg::MAP_WORD_BITS-1:0] used;
	logic [bra_pkg::MAP_WORD_BITS-1:0] seen;
	logic [bra_pkg::BIT_W-1:0]         last_idx [bra_pkg::MAP_WORD_BITS];
	bra_pkg::cnt_t                     base;

	assign base = bra_pkg::CNT_W'(word_idx) << bra_pkg::BIT_W;

	always_comb begin
		bra_pkg::cnt_t page;
		page = '0;
		for (int b = 0; b < bra_pkg::MAP_WORD_BITS; b++) begin
			page    = base | bra_pkg::CNT_W'(b);
			used[b] = word[b] | (page >= limit);
		end
	end

	// highest used bit at or below each position
	always_comb begin
		for (int b = 0; b < bra_pkg::MAP_WORD_BITS; b++) begin
			seen[b]     = 1'b0;
			last_idx[b] = '0;
			for (int j = 0; j < bra_pkg::MAP_WORD_BITS; j++) begin
				if (j <= b && used[j]) begin
					seen[b]     = 1'b1;
					last_idx[b] = bra_pkg::BIT_W'(j);
				end
			end
		end
	end

	always_comb begin
		bra_pkg::cnt_t run_len;
		bra_pkg::cnt_t run_start;
		run_len       = '0;
		run_start     = '0;
		res.hit       = 1'b0;
		res.hit_start = '0;
		for (int b = bra_pkg::MAP_WORD_BITS - 1; b >= 0; b--) begin
			if (seen[b]) begin
				run_len   = bra_pkg::CNT_W'(b) - bra_pkg::CNT_W'(last_idx[b]);
				run_start = base + bra_pkg::CNT_W'(last_idx[b]) + bra_pkg::CNT_W'(1);
			end else begin
				run_len   = carry_len + bra_pkg::CNT_W'(b) + bra_pkg::CNT_W'(1);
				run_start = carry_start;
			end
			if (!used[b] && run_len >= len) begin
				res.hit       = 1'b1;
				res.hit_start = run_start;
			end
		end
		if (seen[bra_pkg::MAP_WORD_BITS-1]) begin
			res.next_len   = bra_pkg::CNT_W'(bra_pkg::MAP_WORD_BITS - 1)
				- bra_pkg::CNT_W'(last_idx[bra_pkg::MAP_WORD_BITS-1]);
			res.next_start = base + bra_pkg::CNT_W'(last_idx[bra_pkg::MAP_WORD_BITS-1])
				+ bra_pkg::CNT_W'(1);
		end else begin
			res.next_len   = carry_len + bra_pkg::CNT_W'(bra_pkg::MAP_WORD_BITS);
			res.next_start = carry_start;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_run_page_allocator.sv -----
// ---------------------------------------------------------------------------
// Bitmap run page allocator
// First-fit page run allocator over a used/free bitmap held in one memory.
// ---------------------------------------------------------------------------
// One request at a time, one response beat per request. Requests that touch
// no page (unused code, negative or zero length, range failure) go straight
// to the response. Allocate reads the bitmap one 32-page word per cycle
// through the single memory read port until the first fitting run or the
// page limit, then rewrites the run; free and mark only rewrite. Each
// rewritten word is read, then written back. The map needs no clearing pass
// after reset. The request channel is ready whenever no request is in
// progress, even while the previous response is waiting.
`default_nettype none

`include "bitmap_run_page_allocator_macros.svh"

module bitmap_run_page_allocator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	bra_req_if.sink                         req,
	bra_rsp_if.source                       rsp,
	input  wire logic                       cfg_we,
	input  wire logic [bra_pkg::CNT_W-1:0]  cfg_wdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_WRD  = 3'd2;
	localparam logic [2:0] S_WWB  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]                   state_q;
	bra_pkg::cnt_t                num_pages_q;
	bra_pkg::cnt_t                len_q;
	logic                         set_q;
	bra_pkg::page_t               wstart_q;
	bra_pkg::page_t               wend_q;
	bra_pkg::word_addr_t          wr_word_q;
	logic [bra_pkg::ADDR_W:0]     rd_addr_q;
	logic                         rd_vld_s1;
	bra_pkg::word_addr_t          word_s1;
	bra_pkg::cnt_t                carry_len_q;
	bra_pkg::cnt_t                carry_start_q;
	logic [1:0]                   status_q;
	bra_pkg::page_t               astart_q;
	logic                         rsp_vld_q;
	logic [1:0]                   rsp_status_q;
	bra_pkg::page_t               rsp_astart_q;

	bra_pkg::cnt_t                limit;
	logic                         more;
	logic                         scan_vld;
	logic                         hit;
	logic                         issue;
	logic                         accept;
	logic                         rsp_load;
	logic                         neg;
	bra_pkg::cnt_t                len_in;
	logic                         range_bad;
	bra_pkg::ram_req_t            ram_req;
	bra_pkg::map_word_t           rd_data;
	bra_pkg::map_word_t           mask;
	logic [bra_pkg::BIT_W-1:0]    lo_bit;
	logic [bra_pkg::BIT_W-1:0]    hi_bit;
	bra_pkg::scan_res_t           scan_res;

	assign limit = (num_pages_q > bra_pkg::PAGE_LIMIT) ? bra_pkg::PAGE_LIMIT : num_pages_q;
	assign more  = bra_pkg::CNT_W'({rd_addr_q, {bra_pkg::BIT_W{1'b0}}}) < limit;

	assign scan_vld = (state_q == S_SCAN) && rd_vld_s1;
	assign hit      = scan_vld && scan_res.hit;
	assign issue    = (state_q == S_SCAN) && more && !hit;

	assign accept    = req.valid && req.ready;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);
	assign neg       = req.run_length[bra_pkg::LEN_W-1];
	assign len_in    = req.run_length[bra_pkg::CNT_W-1:0];
	assign range_bad = (bra_pkg::LEN_W'(req.first_page) + bra_pkg::LEN_W'(len_in))
		> bra_pkg::LEN_W'(limit);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.alloc_start = rsp_astart_q;

	// run mask within the word being rewritten
	always_comb begin
		lo_bit = (wr_word_q == wstart_q[bra_pkg::PAGE_W-1 -: bra_pkg::ADDR_W])
			? wstart_q[bra_pkg::BIT_W-1:0] : '0;
		hi_bit = (wr_word_q == wend_q[bra_pkg::PAGE_W-1 -: bra_pkg::ADDR_W])
			? wend_q[bra_pkg::BIT_W-1:0] : '1;
		mask   = (bra_pkg::ALL_ONES << lo_bit)
			& (bra_pkg::ALL_ONES >> (bra_pkg::BIT_W'(bra_pkg::MAP_WORD_BITS - 1) - hi_bit));
	end

	always_comb begin
		ram_req.rd_en   = issue || (state_q == S_WRD);
		ram_req.rd_addr = (state_q == S_WRD) ? wr_word_q : rd_addr_q[bra_pkg::ADDR_W-1:0];
		ram_req.wr_en   = (state_q == S_WWB);
		ram_req.wr_addr = wr_word_q;
		ram_req.wr_data = set_q ? (rd_data | mask) : (rd_data & ~mask);
	end

	bra_map_ram u_map_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ram_req (ram_req),
		.rd_data (rd_data)
	);

	bra_scan u_scan (
		.word        (rd_data),
		.word_idx    (word_s1),
		.limit       (limit),
		.len         (len_q),
		.carry_len   (carry_len_q),
		.carry_start (carry_start_q),
		.res         (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			num_pages_q   <= bra_pkg::NUM_PAGES_RST;
			rd_vld_s1     <= 1'b0;
			rsp_vld_q     <= 1'b0;
			len_q         <= '0;
			set_q         <= 1'b0;
			wstart_q      <= '0;
			wend_q        <= '0;
			wr_word_q     <= '0;
			rd_addr_q     <= '0;
			word_s1       <= '0;
			carry_len_q   <= '0;
			carry_start_q <= '0;
			status_q      <= bra_pkg::STAT_OK;
			astart_q      <= '0;
			rsp_status_q  <= bra_pkg::STAT_OK;
			rsp_astart_q  <= '0;
		end else begin
			if (cfg_we) begin
				num_pages_q <= cfg_wdata;
			end
			rd_vld_s1 <= issue;
			word_s1   <= rd_addr_q[bra_pkg::ADDR_W-1:0];
			if (rsp_load) begin
				rsp_vld_q    <= 1'b1;
				rsp_status_q <= status_q;
				rsp_astart_q <= astart_q;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						astart_q      <= '0;
						len_q         <= len_in;
						set_q         <= (req.req_type != bra_pkg::REQ_FREE);
						wstart_q      <= req.first_page;
						wend_q        <= bra_pkg::PAGE_W'(bra_pkg::LEN_W'(req.first_page)
							+ bra_pkg::LEN_W'(len_in) - bra_pkg::LEN_W'(1));
						wr_word_q     <= req.first_page[bra_pkg::PAGE_W-1 -: bra_pkg::ADDR_W];
						rd_addr_q     <= '0;
						carry_len_q   <= '0;
						carry_start_q <= '0;
						if (req.req_type == bra_pkg::REQ_NONE) begin
							status_q <= bra_pkg::STAT_OK;
							state_q  <= S_DONE;
						end else if (neg) begin
							status_q <= bra_pkg::STAT_NEG;
							state_q  <= S_DONE;
						end else if (req.req_type == bra_pkg::REQ_ALLOC) begin
							status_q <= bra_pkg::STAT_OK;
							state_q  <= (len_in != '0) ? S_SCAN : S_DONE;
						end else if (range_bad) begin
							status_q <= bra_pkg::STAT_RANGE;
							state_q  <= S_DONE;
						end else begin
							status_q <= bra_pkg::STAT_OK;
							state_q  <= (len_in != '0) ? S_WRD : S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_addr_q <= rd_addr_q + (bra_pkg::ADDR_W + 1)'(1);
					end
					if (scan_vld) begin
						if (scan_res.hit) begin
							wstart_q  <= scan_res.hit_start[bra_pkg::PAGE_W-1:0];
							astart_q  <= scan_res.hit_start[bra_pkg::PAGE_W-1:0];
							wend_q    <= bra_pkg::PAGE_W'(scan_res.hit_start + len_q
								- bra_pkg::CNT_W'(1));
							wr_word_q <= scan_res.hit_start[bra_pkg::PAGE_W-1 -: bra_pkg::ADDR_W];
							state_q   <= S_WRD;
						end else begin
							carry_len_q   <= scan_res.next_len;
							carry_start_q <= scan_res.next_start;
						end
					end else if (!more) begin
						status_q <= bra_pkg::STAT_FULL;
						state_q  <= S_DONE;
					end
				end
				S_WRD: begin
					state_q <= S_WWB;
				end
				S_WWB: begin
					if (wr_word_q == wend_q[bra_pkg::PAGE_W-1 -: bra_pkg::ADDR_W]) begin
						state_q <= S_DONE;
					end else begin
						wr_word_q <= wr_word_q + bra_pkg::ADDR_W'(1);
						state_q   <= S_WRD;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BRA_ASSERT_IMPLIES(a_wr_in_range, state_q == S_WWB, (bra_pkg::CNT_W'(wend_q) < limit) && (wstart_q <= wend_q), "run rewrite outside page limit")
	`BRA_ASSERT_IMPLIES(a_rmw_same_word, ram_req.wr_en, $past(ram_req.rd_en) && ($past(ram_req.rd_addr) == ram_req.wr_addr), "write back without matching read")
	`BRA_ASSERT_IMPLIES(a_scan_in_limit, scan_vld, bra_pkg::CNT_W'({word_s1, {bra_pkg::BIT_W{1'b0}}}) < limit, "scanned word beyond page limit")
	`BRA_ASSERT_NEXT(a_busy_after_accept, accept, state_q != S_IDLE, "request accepted but block idle")

endmodule

`default_nettype wire
